// ===== hw/rtl/btlv_pkg.sv =====
// ----------------------------------------------------------------------------
// btlv_pkg: shared types and constants of the BER TLV stream parser
// Phase, role and error codes, field widths and the records that travel
// between the parser control and the row of end-position cells.
// ----------------------------------------------------------------------------
package btlv_pkg;

  localparam int OCT_W          = 8;
  localparam int TAG_W          = 28;
  localparam int LEN_W          = 32;
  localparam int NEST_W         = 4;
  localparam int CNT_W          = 4;
  localparam int CFG_W          = 4;
  localparam int TAG_OCTETS_MAX = 4;
  localparam int LEN_OCTETS_MAX = 4;

  localparam logic [4:0]       TAG_ESCAPE   = 5'h1F;
  localparam logic [7:0]       LEN_INDEF    = 8'h80;
  localparam logic [CFG_W-1:0] NEST_DEFAULT = 4'd8;

  typedef enum logic [2:0] {
    PH_ID      = 3'd0,
    PH_TAGC    = 3'd1,
    PH_LEN     = 3'd2,
    PH_LENC    = 3'd3,
    PH_CONTENT = 3'd4,
    PH_ERROR   = 3'd5
  } btlv_phase_t;

  typedef enum logic [2:0] {
    ROLE_ID      = 3'd0,
    ROLE_TAGC    = 3'd1,
    ROLE_LEN     = 3'd2,
    ROLE_LENC    = 3'd3,
    ROLE_CONTENT = 3'd4,
    ROLE_IGNORED = 3'd5
  } btlv_role_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_TAG_LONG = 3'd1,
    ERR_LEN_LONG = 3'd2,
    ERR_INDEF    = 3'd3,
    ERR_DEEP     = 3'd4,
    ERR_OVERRUN  = 3'd5
  } btlv_err_t;

  // request from the parser control to the stack row
  typedef struct packed {
    logic             fire;
    logic             restart;
    logic             push;
    logic             done;
    logic [LEN_W-1:0] pos;
    logic [LEN_W:0]   end_new;
  } btlv_stk_req_t;

  // checks against the open parent
  typedef struct packed {
    logic over_pos;
    logic over_end;
  } btlv_stk_stat_t;

  typedef struct packed {
    logic over_pos;
    logic over_end;
    logic close;
  } btlv_cell_stat_t;

  typedef struct packed {
    btlv_role_t        role;
    logic              header_done;
    logic [1:0]        tag_class;
    logic              constructed;
    logic [TAG_W-1:0]  tag_number;
    logic [LEN_W-1:0]  content_length;
    logic [NEST_W-1:0] nest_depth;
    logic [OCT_W-1:0]  content_byte;
    logic              content_last;
    logic [NEST_W-1:0] levels_closed;
    btlv_err_t         error_code;
  } btlv_res_t;

endpackage

// ===== hw/rtl/btlv_ifs.sv =====
// ----------------------------------------------------------------------------
// btlv_ifs: channel interfaces of the BER TLV stream parser
// Byte input channel, result channel and nesting-limit write channel,
// each a valid/ready pair with its payload.
// ----------------------------------------------------------------------------
interface btlv_in_if import btlv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OCT_W-1:0] octet;
  logic             restart;

  modport source (output valid, output octet, output restart, input ready);
  modport sink   (input valid, input octet, input restart, output ready);
endinterface

interface btlv_out_if import btlv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        role;
  logic              header_done;
  logic [1:0]        tag_class;
  logic              constructed;
  logic [TAG_W-1:0]  tag_number;
  logic [LEN_W-1:0]  content_length;
  logic [NEST_W-1:0] nest_depth;
  logic [OCT_W-1:0]  content_byte;
  logic              content_last;
  logic [NEST_W-1:0] levels_closed;
  logic [2:0]        error_code;

  modport source (
    output valid, output role, output header_done, output tag_class,
    output constructed, output tag_number, output content_length,
    output nest_depth, output content_byte, output content_last,
    output levels_closed, output error_code, input ready
  );
  modport sink (
    input valid, input role, input header_done, input tag_class,
    input constructed, input tag_number, input content_length,
    input nest_depth, input content_byte, input content_last,
    input levels_closed, input error_code, output ready
  );
endinterface

interface btlv_cfg_if import btlv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] max_nesting;

  modport source (output valid, output max_nesting, input ready);
  modport sink   (input valid, input max_nesting, output ready);
endinterface

// ===== hw/rtl/btlv_cell.sv =====
// ----------------------------------------------------------------------------
// btlv_cell: one stack level of open constructed objects
// Holds the end position of the object at its level, checks it against
// the current byte when it is the top, and joins the closing chain that
// runs down from the top of the row.
// ----------------------------------------------------------------------------
module btlv_cell import btlv_pkg::*; #(
  parameter int LVL_W = 4,
  parameter int IDX   = 0
) (
  input  logic            clk,
  input  btlv_stk_req_t   req,
  input  logic [LVL_W-1:0] level_cur,
  input  logic            chain_in,
  output logic            chain_out,
  output btlv_cell_stat_t stat
);

  logic [LEN_W-1:0] end_r;
  logic             is_top;
  logic             push_here;
  logic             occupied;
  logic             match;

  assign is_top    = (level_cur == LVL_W'(IDX + 1));
  assign push_here = req.push && (level_cur == LVL_W'(IDX));
  assign occupied  = (level_cur > LVL_W'(IDX)) || push_here;

  // a fresh push only closes on its header byte, i.e. zero length
  assign match = push_here ||
                 ({1'b0, end_r} == ({1'b0, req.pos} + (LEN_W + 1)'(1)));

  always_ff @(posedge clk) begin
    if (req.fire && push_here) begin
      end_r <= req.end_new[LEN_W-1:0];
    end
  end

  assign stat.over_pos = is_top && (req.pos >= end_r);
  assign stat.over_end = is_top && (req.end_new > {1'b0, end_r});
  assign stat.close    = req.done && occupied && match && chain_in;

  // empty levels pass the chain, occupied ones only if they close too
  assign chain_out = occupied ? stat.close : chain_in;

endmodule

// ===== hw/rtl/btlv_stack.sv =====
// ----------------------------------------------------------------------------
// btlv_stack: row of end-position cells and the stack level
// Collects the parent checks of the top cell, counts the levels that close
// at the current byte and keeps the number of open constructed objects.
// ----------------------------------------------------------------------------
module btlv_stack import btlv_pkg::*; #(
  parameter int  MAX_DEPTH = 8,
  localparam int LVL_W     = $clog2(MAX_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  btlv_stk_req_t    req,
  output btlv_stk_stat_t   stat,
  output logic [LVL_W-1:0] level_cur,
  output logic [LVL_W-1:0] level_nxt,
  output logic [LVL_W-1:0] closed
);

  logic [LVL_W-1:0] level_r;
  logic [MAX_DEPTH:0] chain;
  btlv_cell_stat_t  cstat [MAX_DEPTH];

  assign level_cur        = req.restart ? '0 : level_r;
  assign chain[MAX_DEPTH] = 1'b1;

  for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
    btlv_cell #(
      .LVL_W (LVL_W),
      .IDX   (i)
    ) u_cell (
      .clk       (clk),
      .req       (req),
      .level_cur (level_cur),
      .chain_in  (chain[i+1]),
      .chain_out (chain[i]),
      .stat      (cstat[i])
    );
  end

  always_comb begin
    stat   = '0;
    closed = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      stat.over_pos = stat.over_pos | cstat[i].over_pos;
      stat.over_end = stat.over_end | cstat[i].over_end;
      closed        = closed + LVL_W'(cstat[i].close);
    end
  end

  assign level_nxt = level_cur + LVL_W'(req.push) - closed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else if (req.fire) begin
      level_r <= level_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LVL_W'(MAX_DEPTH))
    else $error("stack level above depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    req.fire && req.push |-> level_cur < LVL_W'(MAX_DEPTH))
    else $error("push into full stack");

  a_close_done: assert property (@(posedge clk) disable iff (!rst_n)
    req.fire && (closed != '0) |-> req.done && (stat.over_end == 1'b0 || req.push == 1'b0))
    else $error("levels closed without a finished object");
`endif

endmodule

// ===== hw/rtl/ber_tlv_stream_parser.sv =====
// ----------------------------------------------------------------------------
// ber_tlv_stream_parser: byte-serial BER TLV parser
//
//   channel   dir  handshake            payload
//   in_ch     in   valid/ready          octet, restart
//   out_ch    out  valid/ready          role ... error_code, one word per byte
//   cfg_ch    in   valid/ready (ready=1) max_nesting
//
// One byte per cycle unless stalled; each result comes in the next cycle.
// The path that sets the cycle is the length shift, the end-position add and
// the compare in the top stack cell, then the closing chain down the row.
// in_ch.ready is low only while a result waits and out_ch.ready is low.
// rst_n (synchronous) clears the parser state and sets max_nesting to 8.
// ----------------------------------------------------------------------------
module ber_tlv_stream_parser import btlv_pkg::*; #(
  parameter int MAX_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  btlv_in_if.sink     in_ch,
  btlv_out_if.source  out_ch,
  btlv_cfg_if.sink    cfg_ch
);

  localparam int LVL_W = $clog2(MAX_DEPTH + 1);
  localparam int LIM_W = (LVL_W > CFG_W) ? LVL_W : CFG_W;

  // parser state
  btlv_phase_t       phase_r, phase_nxt, phase_cur;
  btlv_err_t         err_r, err_nxt, err_cur, err_new, early_err;
  logic [LEN_W-1:0]  pos_r, pos_cur;
  logic [TAG_W-1:0]  tag_r, tag_n;
  logic [CNT_W-1:0]  cnt_r, cnt_n, cnt_sat;
  logic [LEN_W-1:0]  len_r, len_n;
  logic [CNT_W-1:0]  left_r, left_n, left_dec;
  logic [1:0]        class_r, class_n;
  logic              constr_r, constr_n;
  logic [LEN_W-1:0]  cont_r, cont_n, cont_dec;
  logic [CFG_W-1:0]  max_nest_r;

  // per-byte decode
  logic              in_fire;
  logic [OCT_W-1:0]  b;
  logic              ignore;
  btlv_role_t        role;
  logic              hdr_raw, hdr_out, hdr_id;
  logic              go_tagc, go_len, go_lenc, go_content;
  logic              prim_done, done, push, clast;
  logic [OCT_W-1:0]  cbyte;
  logic [LEN_W:0]    end_new;
  logic [LIM_W-1:0]  limit;
  logic              at_limit;

  // stack row
  btlv_stk_req_t     stk_req;
  btlv_stk_stat_t    stk_stat;
  logic [LVL_W-1:0]  level_cur, level_nxt, closed;

  // result register
  logic              out_valid_r;
  btlv_res_t         res_r, res_nxt;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign b            = in_ch.octet;

  // restart clears the message before this byte is parsed
  assign phase_cur = in_ch.restart ? PH_ID    : phase_r;
  assign err_cur   = in_ch.restart ? ERR_NONE : err_r;
  assign pos_cur   = in_ch.restart ? '0       : pos_r;
  assign ignore    = (err_cur != ERR_NONE) || (phase_cur == PH_ERROR);

  assign cnt_sat  = (cnt_r == '1) ? cnt_r : cnt_r + CNT_W'(1);
  assign left_dec = left_r - CNT_W'(left_r != '0);
  assign cont_dec = cont_r - LEN_W'(cont_r != '0);

  assign limit    = (LIM_W'(max_nest_r) > LIM_W'(MAX_DEPTH)) ? LIM_W'(MAX_DEPTH)
                                                             : LIM_W'(max_nest_r);
  assign at_limit = (LIM_W'(level_cur) >= limit);

  // field decode of the byte in the current phase
  always_comb begin
    role      = ROLE_IGNORED;
    early_err = ERR_NONE;
    hdr_raw   = 1'b0;
    class_n   = class_r;
    constr_n  = constr_r;
    tag_n     = tag_r;
    cnt_n     = cnt_r;
    len_n     = len_r;
    left_n    = left_r;
    cont_n    = cont_r;
    cbyte     = '0;
    clast     = 1'b0;
    prim_done = 1'b0;
    go_tagc   = 1'b0;
    go_len    = 1'b0;
    go_lenc   = 1'b0;
    if (!ignore) begin
      unique case (phase_cur)
        PH_ID: begin
          role     = ROLE_ID;
          class_n  = b[7:6];
          constr_n = b[5];
          len_n    = '0;
          cnt_n    = '0;
          if (b[4:0] == TAG_ESCAPE) begin
            tag_n   = '0;
            go_tagc = 1'b1;
          end else begin
            tag_n  = TAG_W'(b[4:0]);
            go_len = 1'b1;
          end
        end
        PH_TAGC: begin
          role = ROLE_TAGC;
          if (stk_stat.over_pos) begin
            early_err = ERR_OVERRUN;
          end else begin
            cnt_n = cnt_sat;
            if (cnt_sat > CNT_W'(TAG_OCTETS_MAX)) begin
              early_err = ERR_TAG_LONG;
            end else begin
              tag_n  = {tag_r[TAG_W-8:0], b[6:0]};
              go_len = !b[7];
            end
          end
        end
        PH_LEN: begin
          role = ROLE_LEN;
          if (stk_stat.over_pos) begin
            early_err = ERR_OVERRUN;
          end else if (b == LEN_INDEF) begin
            early_err = ERR_INDEF;
          end else if (b[7]) begin
            if (b[6:0] > 7'(LEN_OCTETS_MAX)) begin
              early_err = ERR_LEN_LONG;
            end else begin
              left_n  = CNT_W'(b[6:0]);
              len_n   = '0;
              go_lenc = 1'b1;
            end
          end else begin
            len_n   = LEN_W'(b);
            hdr_raw = 1'b1;
          end
        end
        PH_LENC: begin
          role = ROLE_LENC;
          if (stk_stat.over_pos) begin
            early_err = ERR_OVERRUN;
          end else if (len_r[LEN_W-1:LEN_W-8] != '0) begin
            early_err = ERR_LEN_LONG;
          end else begin
            len_n   = {len_r[LEN_W-9:0], b};
            left_n  = left_dec;
            hdr_raw = (left_dec == '0);
          end
        end
        PH_CONTENT: begin
          role   = ROLE_CONTENT;
          cbyte  = b;
          cont_n = cont_dec;
          if (cont_dec == '0) begin
            clast     = 1'b1;
            prim_done = 1'b1;
          end
        end
        default: begin
          role = ROLE_IGNORED;
        end
      endcase
    end
  end

  assign end_new = {1'b0, pos_cur} + (LEN_W + 1)'(1) + {1'b0, len_n};

  // finish a header: range, parent and nesting checks, then push, done or content
  always_comb begin
    err_new    = early_err;
    push       = 1'b0;
    done       = prim_done;
    go_content = 1'b0;
    hdr_id     = 1'b0;
    if (hdr_raw && early_err == ERR_NONE) begin
      priority if (end_new[LEN_W]) begin
        err_new = ERR_LEN_LONG;
      end else if (stk_stat.over_end) begin
        err_new = ERR_OVERRUN;
      end else if (constr_n) begin
        if (at_limit) begin
          err_new = ERR_DEEP;
        end else begin
          push   = 1'b1;
          hdr_id = 1'b1;
          done   = (len_n == '0);
        end
      end else if (len_n == '0) begin
        done   = 1'b1;
        hdr_id = 1'b1;
      end else begin
        go_content = 1'b1;
      end
    end
  end

  assign hdr_out = hdr_raw && (err_new == ERR_NONE);
  assign err_nxt = (err_new != ERR_NONE) ? err_new : err_cur;

  // next phase
  always_comb begin
    priority if (err_new != ERR_NONE) begin
      phase_nxt = PH_ERROR;
    end else if (ignore) begin
      phase_nxt = phase_cur;
    end else if (go_tagc) begin
      phase_nxt = PH_TAGC;
    end else if (go_lenc) begin
      phase_nxt = PH_LENC;
    end else if (go_content) begin
      phase_nxt = PH_CONTENT;
    end else if (hdr_id || prim_done) begin
      phase_nxt = PH_ID;
    end else if (go_len) begin
      phase_nxt = PH_LEN;
    end else begin
      phase_nxt = phase_cur;
    end
  end

  assign stk_req.fire    = in_fire;
  assign stk_req.restart = in_ch.restart;
  assign stk_req.push    = push;
  assign stk_req.done    = done;
  assign stk_req.pos     = pos_cur;
  assign stk_req.end_new = end_new;

  btlv_stack #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (stk_req),
    .stat      (stk_stat),
    .level_cur (level_cur),
    .level_nxt (level_nxt),
    .closed    (closed)
  );

  // result word; an ignored byte reports only role, depth and error
  always_comb begin
    res_nxt            = '0;
    res_nxt.role       = role;
    res_nxt.nest_depth = NEST_W'(level_nxt);
    res_nxt.error_code = err_nxt;
    if (!ignore) begin
      res_nxt.header_done    = hdr_out;
      res_nxt.tag_class      = class_n;
      res_nxt.constructed    = constr_n;
      res_nxt.tag_number     = tag_n;
      res_nxt.content_length = len_n;
      res_nxt.content_byte   = cbyte;
      res_nxt.content_last   = clast;
      res_nxt.levels_closed  = NEST_W'(closed);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_ID;
      err_r      <= ERR_NONE;
      pos_r      <= '0;
      tag_r      <= '0;
      cnt_r      <= '0;
      len_r      <= '0;
      left_r     <= '0;
      class_r    <= '0;
      constr_r   <= 1'b0;
      cont_r     <= '0;
      max_nest_r <= NEST_DEFAULT;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        max_nest_r <= cfg_ch.max_nesting;
      end
      if (in_fire) begin
        phase_r  <= phase_nxt;
        err_r    <= err_nxt;
        pos_r    <= pos_cur + LEN_W'(1);
        tag_r    <= tag_n;
        cnt_r    <= cnt_n;
        len_r    <= len_n;
        left_r   <= left_n;
        class_r  <= class_n;
        constr_r <= constr_n;
        cont_r   <= go_content ? len_n : cont_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.role           = res_r.role;
  assign out_ch.header_done    = res_r.header_done;
  assign out_ch.tag_class      = res_r.tag_class;
  assign out_ch.constructed    = res_r.constructed;
  assign out_ch.tag_number     = res_r.tag_number;
  assign out_ch.content_length = res_r.content_length;
  assign out_ch.nest_depth     = res_r.nest_depth;
  assign out_ch.content_byte   = res_r.content_byte;
  assign out_ch.content_last   = res_r.content_last;
  assign out_ch.levels_closed  = res_r.levels_closed;
  assign out_ch.error_code     = res_r.error_code;

`ifndef NO_ASSERTIONS
  a_err_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != ERR_NONE) == (phase_r == PH_ERROR))
    else $error("sticky error and error phase disagree");

  a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted byte produced no result");

  a_last_role: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.content_last |-> res_r.role == ROLE_CONTENT)
    else $error("last mark outside content");
`endif

endmodule
